FILE: sv/radix_digit_converter_defines.svh
// Assertion macros for the radix digit converter.
// Used by the RTL files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef RADIX_DIGIT_CONVERTER_DEFINES_SVH
`define RADIX_DIGIT_CONVERTER_DEFINES_SVH
`ifndef SYNTH
`define RDC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RDC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RDC_ASSERT(lbl, prop, msg)
`define RDC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: sv/rdc_pkg.sv
// Shared constants and control/status types for the radix digit converter.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none
package rdc_pkg;
    localparam int VALUE_BITS = 32;
    localparam int STEP_BITS  = 8;
    localparam int DIV_CYCLES = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_BITS   = DIV_CYCLES * STEP_BITS;
    localparam int DIV_CNT_W  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);
    localparam int ADDR_W     = $clog2(VALUE_BITS);
    localparam int IN_VALUE_W = 32;
    localparam int BASE_W     = 6;
    localparam int DIGIT_W    = 6;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 8;

    localparam logic [BASE_W-1:0] MIN_BASE = BASE_W'(2);
    localparam logic [BASE_W-1:0] MAX_BASE = BASE_W'(36);

    typedef struct packed {
        logic load;
        logic div_step;
        logic digit_wb;
        logic emit_load;
    } rdc_cmd_t;

    typedef struct packed {
        logic q_zero;
        logic cnt_last;
        logic out_free;
    } rdc_sts_t;
endpackage
`default_nettype wire

FILE: sv/rdc_ctrl.sv
// Controller of the radix digit converter: sequences division, write-back and readout.
// Depends on rdc_pkg for the command and status types.
`default_nettype none
module rdc_ctrl
    import rdc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  rdc_sts_t      sts,
    output rdc_cmd_t      cmd
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_WB   = 3'd2;
    localparam logic [2:0] ST_READ = 3'd3;
    localparam logic [2:0] ST_LOAD = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == DIV_CNT_W'(DIV_CYCLES - 1))
                begin
                    state_next = ST_WB;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_WB:
            begin
                cmd.digit_wb = 1'b1;
                step_next    = '0;
                // The quotient is complete here, so zero means this was the top digit.
                state_next   = sts.q_zero ? ST_READ : ST_DIV;
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    state_next    = sts.cnt_last ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end
endmodule
`default_nettype wire

FILE: sv/rdc_datapath.sv
// Datapath of the radix digit converter: restoring divider, digit memory, output register.
// Depends on rdc_pkg and on the assertion macros in radix_digit_converter_defines.svh.
`default_nettype none
`include "radix_digit_converter_defines.svh"
module rdc_datapath
    import rdc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [IN_VALUE_W-1:0] value,
    input  wire logic [BASE_W-1:0]     base,
    input  rdc_cmd_t                   cmd,
    output rdc_sts_t                   sts,
    input  wire logic                  m_tready,
    output logic                       m_tvalid,
    output logic [DIGIT_W-1:0]         digit,
    output logic                       last_digit
);
    logic [PAD_BITS-1:0]  q_reg, q_next;
    logic [BASE_W-1:0]    rem_reg, rem_next;
    logic [BASE_W-1:0]    base_reg, base_clamped;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIGIT_W-1:0]   mem [VALUE_BITS];
    logic [DIGIT_W-1:0]   rd_data_reg;
    logic [ADDR_W-1:0]    rd_addr;
    logic [PAD_BITS-1:0]  value_ext;
    logic [STEP_BITS-1:0] qbits;
    logic                 out_valid_reg;
    logic [DIGIT_W-1:0]   out_digit_reg;
    logic                 out_last_reg;

    always_comb
    begin
        value_ext = PAD_BITS'(value);
        for (int i = 0; i < PAD_BITS; i++)
        begin
            if (i >= VALUE_BITS)
            begin
                value_ext[i] = 1'b0;
            end
        end
    end

    always_comb
    begin
        if (base < MIN_BASE)
        begin
            base_clamped = MIN_BASE;
        end
        else if (base > MAX_BASE)
        begin
            base_clamped = MAX_BASE;
        end
        else
        begin
            base_clamped = base;
        end
    end

    // Restoring division, STEP_BITS quotient bits per cycle, remainder stays below the base.
    always_comb
    begin
        logic [BASE_W:0] trial;
        rem_next = rem_reg;
        qbits    = '0;
        for (int i = 0; i < STEP_BITS; i++)
        begin
            trial = {rem_next, q_reg[PAD_BITS-1-i]};
            if (trial >= {1'b0, base_reg})
            begin
                qbits[STEP_BITS-1-i] = 1'b1;
                rem_next = BASE_W'(trial - {1'b0, base_reg});
            end
            else
            begin
                rem_next = trial[BASE_W-1:0];
            end
        end
        q_next = (q_reg << STEP_BITS) | PAD_BITS'(qbits);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            q_reg    <= value_ext;
            rem_reg  <= '0;
            base_reg <= base_clamped;
        end
        else if (cmd.div_step)
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
        else if (cmd.digit_wb)
        begin
            rem_reg <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.digit_wb)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        else if (cmd.emit_load)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Digits are stored least significant first and read back from the top down.
    assign rd_addr = ADDR_W'(cnt_reg - 1'b1);

    always_ff @(posedge clk)
    begin
        if (cmd.digit_wb)
        begin
            mem[cnt_reg[ADDR_W-1:0]] <= rem_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            out_digit_reg <= rd_data_reg;
            out_last_reg  <= (cnt_reg == CNT_W'(1));
        end
    end

    assign sts.q_zero   = (q_reg == '0);
    assign sts.cnt_last = (cnt_reg == CNT_W'(1));
    assign sts.out_free = !out_valid_reg || m_tready;

    assign m_tvalid   = out_valid_reg;
    assign digit      = out_digit_reg;
    assign last_digit = out_last_reg;

    `RDC_ASSERT_ALWAYS(a_cnt_range, (!rst_n || cnt_reg <= CNT_W'(VALUE_BITS)), "digit count beyond store depth")
    `RDC_ASSERT(a_rem_below_base, cmd.div_step |-> (rem_reg < base_reg), "remainder not below base")
    `RDC_ASSERT(a_base_clamped, cmd.div_step |-> (base_reg >= MIN_BASE && base_reg <= MAX_BASE), "base out of range")
    `RDC_ASSERT(a_emit_nonempty, cmd.emit_load |-> (cnt_reg != '0 && sts.out_free), "emit with no digit or busy output")
endmodule
`default_nettype wire

FILE: sv/radix_digit_converter.sv
// Top level of the radix digit converter: stream ports, controller and datapath.
// Depends on rdc_pkg, rdc_ctrl and rdc_datapath.
//
// Channel   Direction  Payload
// s_*       in         value [31:0], base [37:32]
// m_*       out        digit [5:0], last_digit on tlast
//
// An item is accepted and divided into up to 32 digits, each produced by an
// 8-bit-per-cycle restoring divider plus a memory write-back; each digit is then
// read from the digit memory and loaded into the output register.
// Reset is asynchronous and clears the controller, the digit count and the output valid.
// A stalled output only holds the readout; the last digit may wait in the output register
// while the next item is accepted and divided.
`default_nettype none
module radix_digit_converter
    import rdc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // value [31:0], base [37:32], zero pad
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,   // digit [5:0], zero pad
    output logic                     m_tlast
);
    rdc_cmd_t           cmd;
    rdc_sts_t           sts;
    logic [DIGIT_W-1:0] digit;

    rdc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rdc_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (s_tdata[IN_VALUE_W-1:0]),
        .base       (s_tdata[IN_VALUE_W +: BASE_W]),
        .cmd        (cmd),
        .sts        (sts),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .digit      (digit),
        .last_digit (m_tlast)
    );

    assign m_tdata = M_DATA_W'(digit);
endmodule
`default_nettype wire
